FILE: src/bcce_pkg.sv
package bcce_pkg;

   localparam int NUM_REGS    = 16;
   localparam int PROG_BYTES  = 256;
   localparam int REG_W       = 32;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int PC_W        = $clog2(PROG_BYTES);
   localparam int LEN_W       = PC_W + 1;
   localparam int TARGET_W    = PC_W + 2;
   localparam int REM_W       = 16;
   localparam int REM_STEPS   = 4;
   localparam int REM_CYCLES  = REM_W / REM_STEPS;
   localparam int REM_CNT_W   = $clog2(REM_CYCLES);
   localparam int NEG_SHIFT   = 7;

   localparam logic [7:0] OP_INC  = 8'h01;
   localparam logic [7:0] OP_DEC  = 8'h02;
   localparam logic [7:0] OP_MOV  = 8'h03;
   localparam logic [7:0] OP_MOVC = 8'h04;
   localparam logic [7:0] OP_LSL  = 8'h05;
   localparam logic [7:0] OP_LSR  = 8'h06;
   localparam logic [7:0] OP_JMP  = 8'h07;
   localparam logic [7:0] OP_JZ   = 8'h08;
   localparam logic [7:0] OP_JNZ  = 8'h09;
   localparam logic [7:0] OP_JFE  = 8'h0A;
   localparam logic [7:0] OP_RET  = 8'h0B;
   localparam logic [7:0] OP_ADD  = 8'h0C;
   localparam logic [7:0] OP_SUB  = 8'h0D;
   localparam logic [7:0] OP_XOR  = 8'h0E;
   localparam logic [7:0] OP_OR   = 8'h0F;
   localparam logic [7:0] OP_IN   = 8'h10;
   localparam logic [7:0] OP_OUT  = 8'h11;

   typedef struct packed {
      logic                        start;
      logic signed [TARGET_W-1:0]  target;
      logic [LEN_W-1:0]            length;
   } bcce_wrap_req_type;

   typedef struct packed {
      logic            done;
      logic [PC_W-1:0] pc;
   } bcce_wrap_rsp_type;

endpackage

FILE: src/bcce_pc_wrap.sv
module bcce_pc_wrap
   import bcce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  bcce_wrap_req_type wrap_req,
   output bcce_wrap_rsp_type wrap_rsp
);

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     len_ff;
   logic [REM_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 in_range;
   logic [REM_W-1:0]     start_val;

   // A target already inside the program needs no reduction.
   assign in_range = !wrap_req.target[TARGET_W-1] &&
                     ({1'b0, wrap_req.target[TARGET_W-2:0]} < wrap_req.length);

   // A negative target is lifted by a multiple of the length so that it stays congruent.
   assign start_val = wrap_req.target[TARGET_W-1] ?
                      REM_W'(REM_W'(wrap_req.length) << NEG_SHIFT) +
                      REM_W'(unsigned'(REM_W'(signed'(wrap_req.target)))) :
                      REM_W'(wrap_req.target[TARGET_W-2:0]);

   // Restoring remainder: a few compare-and-subtract steps per cycle, largest multiple first.
   always_comb begin
      logic [REM_W+LEN_W-1:0] acc;
      logic [REM_W+LEN_W-1:0] sub;
      acc = (REM_W+LEN_W)'(rem_ff);
      for (int j = 0; j < REM_STEPS; j++) begin
         sub = (REM_W+LEN_W)'(len_ff) <<
               (4'(REM_W - 1) - {cnt_ff, 2'b00} - 4'(j));
         if (acc >= sub) begin
            acc = acc - sub;
         end
      end
      rem_in = acc[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (wrap_req.start) begin
            cnt_ff  <= '0;
            busy_ff <= !in_range;
            done_ff <= in_range;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == REM_CNT_W'(REM_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wrap_req.start) begin
         rem_ff <= start_val;
         len_ff <= wrap_req.length;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign wrap_rsp.done = done_ff;
   assign wrap_rsp.pc   = rem_ff[PC_W-1:0];

endmodule

FILE: src/byte_code_cpu_executor_top.sv
// A request passes through the execute state, the wrap state (skipped by RET and once
// halted) and the output state, which waits while rsp_tready holds the response.
// A new request is taken only in the idle state, after the last response is loaded; the
// modulo unit, which retires four remainder bits per cycle, sets how long wrap lasts.
// Reset (synchronous, active high) clears state, flags, program counter and response
// valid, sets the program length to 256; the register file reads as zero until written.
module byte_code_cpu_executor_top
   import bcce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,  // opcode[7:0], operand[15:8], in_char[23:16]
   input  logic          req_tuser,  // in_available
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [23:0]   rsp_tdata,  // next_pc[7:0], out_char[15:8], char_taken[16],
                                     // halted[17], zero fill[23:18]
   output logic          rsp_tuser,  // out_valid
   input  logic          csr_we,
   input  logic [8:0]    csr_wdata   // program_length
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WRAP = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]     len_ff, len_in;
   logic [PC_W-1:0]      pc_ff;
   logic                 zero_ff, end_ff, halt_ff;

   logic [7:0]           opcode_ff, operand_ff, in_char_ff;
   logic                 in_avail_ff;

   logic [REG_W-1:0]     rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0]  rf_vld_ff;
   logic [REG_W-1:0]     rdx_ff, rdy_ff;
   logic                 rdx_vld_ff, rdy_vld_ff;
   logic [REG_W-1:0]     rx, ry;

   logic                 accept;
   logic                 exec_live;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] wr_addr;
   logic [REG_W-1:0]     wr_data;
   logic [REG_W-1:0]     res;
   logic                 set_z, jump, ret_op, end_set, taken, outv;

   logic                 rsp_valid_ff;
   logic [PC_W-1:0]      rsp_pc_ff;
   logic [7:0]           rsp_char_ff, out_char_ff;
   logic                 rsp_taken_ff, rsp_halt_ff, rsp_outv_ff;
   logic                 taken_ff, outv_ff;
   logic                 rsp_load;

   bcce_wrap_req_type    wrap_req;
   bcce_wrap_rsp_type    wrap_rsp;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign exec_live  = (state_ff == S_EXEC) && !halt_ff;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // A length of zero behaves as one, anything above the program size as the size.
   always_comb begin
      len_in = len_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            len_in = LEN_W'(1);
         end else if (csr_wdata > LEN_W'(PROG_BYTES)) begin
            len_in = LEN_W'(PROG_BYTES);
         end else begin
            len_in = csr_wdata;
         end
      end
   end

   // Register file: written in the execute cycle, read when the request is taken.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rdx_ff     <= rf_mem[req_tdata[11:8]];
         rdy_ff     <= rf_mem[req_tdata[15:12]];
         rdx_vld_ff <= rf_vld_ff[req_tdata[11:8]];
         rdy_vld_ff <= rf_vld_ff[req_tdata[15:12]];
      end
   end

   assign rx = rdx_vld_ff ? rdx_ff : '0;
   assign ry = rdy_vld_ff ? rdy_ff : '0;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = operand_ff[REG_IDX_W-1:0];
      res     = '0;
      set_z   = 1'b0;
      jump    = 1'b0;
      ret_op  = 1'b0;
      end_set = 1'b0;
      taken   = 1'b0;
      outv    = 1'b0;
      case (opcode_ff)
         OP_INC: begin
            res = rx + REG_W'(1);
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_DEC: begin
            res = rx - REG_W'(1);
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_MOV: begin
            res = ry;
            wr_en = 1'b1;
         end
         OP_MOVC: begin
            res = {{(REG_W-8){operand_ff[7]}}, operand_ff};
            wr_addr = '0;
            wr_en = 1'b1;
         end
         OP_LSL: begin
            res = {rx[REG_W-2:0], 1'b0};
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_LSR: begin
            res = {rx[REG_W-1], rx[REG_W-1:1]};
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_JMP: jump = 1'b1;
         OP_JZ:  jump = zero_ff;
         OP_JNZ: jump = !zero_ff;
         OP_JFE: jump = end_ff;
         OP_RET: ret_op = 1'b1;
         OP_ADD: begin
            res = rx + ry;
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_SUB: begin
            res = rx - ry;
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_XOR: begin
            res = rx ^ ry;
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_OR: begin
            res = rx | ry;
            wr_en = 1'b1;
            set_z = 1'b1;
         end
         OP_IN: begin
            res = {{(REG_W-8){in_char_ff[7]}}, in_char_ff};
            wr_en = in_avail_ff;
            taken = in_avail_ff;
            end_set = !in_avail_ff;
         end
         OP_OUT: outv = 1'b1;
         default: ;
      endcase
      wr_en   = wr_en && exec_live;
      wr_data = res;
   end

   assign wrap_req.start  = exec_live && !ret_op;
   assign wrap_req.length = len_ff;
   assign wrap_req.target = jump ?
                            signed'({2'b00, pc_ff}) +
                            signed'({{2{operand_ff[7]}}, operand_ff}) :
                            signed'({2'b00, pc_ff}) + signed'(TARGET_W'(2));

   bcce_pc_wrap u_pc_wrap (
      .clock    (clock),
      .reset    (reset),
      .wrap_req (wrap_req),
      .wrap_rsp (wrap_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (halt_ff || ret_op) begin
               state_in = S_OUT;
            end else begin
               state_in = S_WRAP;
            end
         end
         S_WRAP: if (wrap_rsp.done) begin
            state_in = S_OUT;
         end
         S_OUT: if (rsp_load) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LEN_W'(PROG_BYTES);
         pc_ff        <= '0;
         zero_ff      <= 1'b0;
         end_ff       <= 1'b0;
         halt_ff      <= 1'b0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         if (wr_en) begin
            rf_vld_ff[wr_addr] <= 1'b1;
         end
         if (exec_live) begin
            if (set_z) begin
               zero_ff <= (res == '0);
            end
            if (end_set) begin
               end_ff <= 1'b1;
            end
            if (ret_op) begin
               halt_ff <= 1'b1;
            end
         end
         if ((state_ff == S_WRAP) && wrap_rsp.done) begin
            pc_ff <= wrap_rsp.pc;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff   <= req_tdata[7:0];
         operand_ff  <= req_tdata[15:8];
         in_char_ff  <= req_tdata[23:16];
         in_avail_ff <= req_tuser;
      end
      if (state_ff == S_EXEC) begin
         out_char_ff <= exec_live && outv ? rx[7:0] : 8'h00;
         outv_ff     <= exec_live && outv;
         taken_ff    <= exec_live && taken;
      end
      if (rsp_load) begin
         rsp_pc_ff    <= pc_ff;
         rsp_char_ff  <= out_char_ff;
         rsp_outv_ff  <= outv_ff;
         rsp_taken_ff <= taken_ff;
         rsp_halt_ff  <= halt_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_halt_ff, rsp_taken_ff, rsp_char_ff, rsp_pc_ff};
   assign rsp_tuser  = rsp_outv_ff;

endmodule

FILE: src/bcce_checker.sv
module bcce_checker
   import bcce_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic seen_halt_ff;

   // Remembers that a halted response has been delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[17]) begin
         seen_halt_ff <= 1'b1;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_halt_ff && rsp_tvalid |-> rsp_tdata[17])
      else $error("response after halt is not marked halted");

   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> !rsp_tuser && !rsp_tdata[16] && rsp_tdata[15:8] == 8'h00)
      else $error("halted response carries input or output activity");

   a_char_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tdata[16]))
      else $error("character both emitted and consumed");

endmodule

bind byte_code_cpu_executor_top bcce_checker u_bcce_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
